// ===== src/nca_pkg.sv =====
package nca_pkg;

  localparam int MAX_LOG_N = 12;
  localparam int DEPTH     = 1 << MAX_LOG_N;
  localparam int ADDR_W    = MAX_LOG_N;
  localparam int LOG_W     = $clog2(MAX_LOG_N + 1);
  localparam int VAL_W     = 63;
  localparam int GAL_W     = 13;
  localparam int SIZE_W    = 4;
  localparam int IDX_W     = 12;
  localparam int PROD_W    = ADDR_W + GAL_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAL_W-1:0]  GALOIS_RESET  = GAL_W'(1);
  localparam logic [SIZE_W-1:0] LOG_RESET     = SIZE_W'(12);
  localparam logic [VAL_W-1:0]  MODULUS_RESET = {VAL_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GALOIS_INDEX,
    CFG_LOG_SIZE,
    CFG_MODULUS
  } cfg_reg_t;

  typedef enum logic {
    REQ_WRITE,
    REQ_READ
  } req_kind_t;

  typedef struct packed {
    logic [GAL_W-1:0]  galois_index;
    logic [LOG_W-1:0]  log_eff;
    logic [ADDR_W-1:0] nmask;
    logic [VAL_W-1:0]  modulus;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } wr_port_t;

  function automatic logic [ADDR_W-1:0] size_mask(input logic [LOG_W-1:0] lg);
    logic [ADDR_W-1:0] m;
    for (int i = 0; i < ADDR_W; i++) begin
      m[i] = (i < int'(lg));
    end
    return m;
  endfunction

endpackage

// ===== src/nca_if.sv =====
interface nca_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [nca_pkg::VAL_W-1:0]   coeff_value;
  logic [nca_pkg::IDX_W-1:0]   read_index;

  modport source (output valid, req_type, coeff_value, read_index, input ready);
  modport sink   (input valid, req_type, coeff_value, read_index, output ready);
endinterface

interface nca_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [nca_pkg::VAL_W-1:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface

interface nca_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nca_pkg::CFG_IDX_W-1:0] index;
  logic [nca_pkg::VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/negacyclic_automorphism.sv =====
// Negacyclic automorphism X -> X^k on polynomials mod X^n+1, coefficients mod Q.
// Write transactions stream coefficients in order; each lands at (i*k) mod n in a
// 4096 x 63 single-port-write memory, negated mod Q when bit log2(n) of i*k is set.
// A write is registered in the mapping stage and reaches the memory from there;
// a read transaction returns the entry at read_index masked to n-1 through the
// registered memory read and the output register, holding the input while the
// read is pending. A result waiting for rsp ready holds off further transactions.
// Writes still in flight are forwarded to reads of the same entry.
// Entries must be written by a full pass before they are read. Configuration
// writes are taken at any time but must only change while the block is idle.
module negacyclic_automorphism (
  input logic      clk,
  input logic      rst,
  nca_cfg_if.sink  cfg,
  nca_req_if.sink  req,
  nca_rsp_if.source rsp
);

  logic [nca_pkg::GAL_W-1:0]  galois_index;
  logic [nca_pkg::SIZE_W-1:0] log_size;
  logic [nca_pkg::VAL_W-1:0]  modulus;
  nca_pkg::cfg_t              cfg_eff;

  logic                       rd_fire;
  logic                       wr_fire;
  logic [nca_pkg::ADDR_W-1:0] rd_addr;
  nca_pkg::wr_port_t          wr;
  logic [nca_pkg::VAL_W-1:0]  ram_q;

  logic                       rd_pend;
  logic                       fwd_hit;
  logic [nca_pkg::VAL_W-1:0]  fwd_data;
  logic                       out_valid;
  logic [nca_pkg::VAL_W-1:0]  out_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      galois_index <= nca_pkg::GALOIS_RESET;
      log_size     <= nca_pkg::LOG_RESET;
      modulus      <= nca_pkg::MODULUS_RESET;
    end else if (cfg.valid) begin
      case (nca_pkg::cfg_reg_t'(cfg.index))
        nca_pkg::CFG_GALOIS_INDEX: galois_index <= cfg.data[nca_pkg::GAL_W-1:0];
        nca_pkg::CFG_LOG_SIZE:     log_size     <= cfg.data[nca_pkg::SIZE_W-1:0];
        nca_pkg::CFG_MODULUS:      modulus      <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_eff.galois_index = galois_index;
    if (int'(log_size) > nca_pkg::MAX_LOG_N) begin
      cfg_eff.log_eff = nca_pkg::LOG_W'(nca_pkg::MAX_LOG_N);
    end else begin
      cfg_eff.log_eff = nca_pkg::LOG_W'(log_size);
    end
    cfg_eff.nmask   = nca_pkg::size_mask(cfg_eff.log_eff);
    cfg_eff.modulus = modulus;
  end

  assign req.ready = !rd_pend && (!out_valid || rsp.ready);
  assign rd_fire   = req.valid && req.ready && (req.req_type == nca_pkg::REQ_READ);
  assign wr_fire   = req.valid && req.ready && (req.req_type == nca_pkg::REQ_WRITE);
  assign rd_addr   = nca_pkg::ADDR_W'(req.read_index) & cfg_eff.nmask;

  nca_wr_map u_wr_map (
    .clk         (clk),
    .rst         (rst),
    .wr_fire     (wr_fire),
    .coeff_value (req.coeff_value),
    .cfg         (cfg_eff),
    .wr          (wr)
  );

  nca_ram #(
    .WIDTH (nca_pkg::VAL_W),
    .DEPTH (nca_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_fire),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= rd_fire;
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a write landing in the same cycle as the read bypasses the memory
  always_ff @(posedge clk) begin
    if (rd_fire) begin
      fwd_hit  <= wr.en && (wr.addr == rd_addr);
      fwd_data <= wr.data;
    end
    if (rd_pend) begin
      out_value <= fwd_hit ? fwd_data : ram_q;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.out_value = out_value;

`ifndef SYNTHESIS
  a_pend_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("read data would overwrite a waiting result");

  a_pend_to_valid: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> out_valid)
    else $error("read data not presented");

  a_wr_from_accept: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> $past(req.valid && req.ready && (req.req_type == nca_pkg::REQ_WRITE)))
    else $error("memory write without a write transaction");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(req.valid && req.ready && (req.req_type == nca_pkg::REQ_READ)))
    else $error("read pending without a read transaction");
`endif

endmodule

// ===== src/nca_ram.sv =====
module nca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/nca_wr_map.sv =====
module nca_wr_map (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_fire,
  input  logic [nca_pkg::VAL_W-1:0] coeff_value,
  input  nca_pkg::cfg_t             cfg,
  output nca_pkg::wr_port_t         wr
);

  logic [nca_pkg::ADDR_W-1:0] wr_pos;
  logic [nca_pkg::ADDR_W-1:0] wr_pos_next;
  logic [nca_pkg::ADDR_W-1:0] pos;
  logic [nca_pkg::PROD_W-1:0] prod;
  logic [nca_pkg::ADDR_W:0]   neg_bits;
  logic [nca_pkg::ADDR_W-1:0] dest_next;
  logic                       neg_next;

  logic                       s1_valid;
  logic [nca_pkg::ADDR_W-1:0] dest;
  logic                       neg;
  logic [nca_pkg::VAL_W-1:0]  value;

  // position times exponent, low bits give the slot, bit log_n the sign
  always_comb begin
    pos         = wr_pos & cfg.nmask;
    prod        = nca_pkg::PROD_W'(pos) * nca_pkg::PROD_W'(cfg.galois_index);
    neg_bits    = prod[nca_pkg::ADDR_W:0];
    dest_next   = prod[nca_pkg::ADDR_W-1:0] & cfg.nmask;
    neg_next    = neg_bits[cfg.log_eff];
    wr_pos_next = (pos + nca_pkg::ADDR_W'(1)) & cfg.nmask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wr_pos   <= '0;
    end else begin
      s1_valid <= wr_fire;
      if (wr_fire) begin
        wr_pos <= wr_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      dest  <= dest_next;
      neg   <= neg_next;
      value <= coeff_value;
    end
  end

  always_comb begin
    wr.en   = s1_valid;
    wr.addr = dest;
    if (neg && (value != '0)) begin
      wr.data = cfg.modulus - value;
    end else begin
      wr.data = value;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import nca_pkg::*;

  localparam int LIMIT = 300000;
  localparam logic [VAL_W-1:0] COEFF_MAX = {{(VAL_W-1){1'b1}}, 1'b0};

  class galois_check;
    logic [VAL_W-1:0]  store [DEPTH];
    bit                written [DEPTH];
    logic [ADDR_W-1:0] wpos;
    logic [GAL_W-1:0]  galois;
    logic [SIZE_W-1:0] log_size;
    logic [VAL_W-1:0]  modulus;
    logic [VAL_W-1:0]  expected_coeffs [$];
    int                errors;

    function new();
      foreach (written[e]) written[e] = 0;
      wpos = '0;
      galois = GALOIS_RESET;
      log_size = LOG_RESET;
      modulus = MODULUS_RESET;
      errors = 0;
    endfunction

    function int eff_log();
      return (log_size > MAX_LOG_N) ? MAX_LOG_N : int'(log_size);
    endfunction

    function logic [ADDR_W-1:0] size_of_mask();
      return ADDR_W'((1 << eff_log()) - 1);
    endfunction

    function void note_config(cfg_reg_t r, logic [VAL_W-1:0] d);
      case (r)
        CFG_GALOIS_INDEX: galois = d[GAL_W-1:0];
        CFG_LOG_SIZE:     log_size = d[SIZE_W-1:0];
        CFG_MODULUS:      modulus = d;
        default: ;
      endcase
    endfunction

    // permuted placement with sign flip on the wrap bit of i*k
    function void apply_request(req_kind_t kind, logic [VAL_W-1:0] v, logic [IDX_W-1:0] idx);
      logic [ADDR_W-1:0] nm, pos, dest;
      logic [PROD_W-1:0] prod;
      logic [VAL_W-1:0]  w;
      int                lg;
      lg = eff_log();
      nm = size_of_mask();
      if (kind == REQ_READ) begin
        expected_coeffs.push_back(store[idx & nm]);
      end else begin
        pos = wpos & nm;
        prod = PROD_W'(pos) * PROD_W'(galois);
        dest = prod[ADDR_W-1:0] & nm;
        w = v;
        if (prod[lg] && v != '0) w = modulus - v;
        store[dest] = w;
        written[dest] = 1;
        wpos = (pos + 1'b1) & nm;
      end
    endfunction

    function void check_result(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (expected_coeffs.size() == 0) begin
        $display("%0t: unexpected read result, expected none, got %h", $time, got);
        errors++;
      end else begin
        want = expected_coeffs.pop_front();
        if (got !== want) begin
          $display("%0t: out_value mismatch, expected %h, got %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_coeffs.size();
    endfunction

    function bit any_readable();
      logic [ADDR_W-1:0] nm;
      nm = size_of_mask();
      for (int e = 0; e <= int'(nm); e++) begin
        if (written[e]) return 1;
      end
      return 0;
    endfunction

    // only entries that were written at some point may be read
    function logic [IDX_W-1:0] pick_read_index();
      logic [ADDR_W-1:0] nm;
      logic [IDX_W-1:0]  idx;
      int                start, e;
      nm = size_of_mask();
      repeat (8) begin
        idx = IDX_W'($urandom);
        if (written[idx & nm]) return idx;
      end
      start = $urandom_range(0, int'(nm));
      for (int k = 0; k <= int'(nm); k++) begin
        e = (start + k) & int'(nm);
        if (written[e]) return (IDX_W'($urandom) & ~nm) | IDX_W'(e);
      end
      return '0;
    endfunction
  endclass

  logic clk, rst;
  int   cycles;
  int   sent_items;
  int   stall_left;
  bit   idle_en;

  nca_cfg_if cfg_ch ();
  nca_req_if req_ch ();
  nca_rsp_if rsp_ch ();

  galois_check sb = new();

  negacyclic_automorphism dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (idle_en && stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.out_value);
  end

  function automatic logic [VAL_W-1:0] rand63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (r[VAL_W-1:0] == {VAL_W{1'b1}}) return COEFF_MAX;
    return r[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] pick_coeff();
    logic [VAL_W-1:0] q;
    q = sb.modulus;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COEFF_MAX;
      2: return (q == '0) ? '0 : q - 1'b1;
      3: return (q > COEFF_MAX) ? COEFF_MAX : q;
      4: return VAL_W'($urandom_range(1, 3));
      default: return rand63();
    endcase
  endfunction

  task automatic send_req(req_kind_t kind, logic [VAL_W-1:0] v, logic [IDX_W-1:0] idx);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.coeff_value <= v;
    req_ch.read_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.apply_request(kind, v, idx);
    sent_items++;
  endtask

  task automatic send_write(logic [VAL_W-1:0] v);
    send_req(REQ_WRITE, v, IDX_W'($urandom));
  endtask

  task automatic send_read(logic [IDX_W-1:0] idx);
    send_req(REQ_READ, rand63(), idx);
  endtask

  task automatic req_stop();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // sender holds off until every read has answered and writes have drained
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t r, logic [VAL_W-1:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.note_config(r, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase();
    int n;
    req_stop();
    wait_idle();
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 6))
        0: write_cfg(CFG_GALOIS_INDEX, VAL_W'(1));
        1: write_cfg(CFG_GALOIS_INDEX, VAL_W'(8191));
        2: write_cfg(CFG_GALOIS_INDEX, VAL_W'(2 * $urandom_range(1, 4095)));
        3: write_cfg(CFG_GALOIS_INDEX, VAL_W'(4096));
        default: write_cfg(CFG_GALOIS_INDEX, VAL_W'(2 * $urandom_range(0, 4095) + 1));
      endcase
    end
    if ($urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 9))
        0: write_cfg(CFG_LOG_SIZE, VAL_W'(1));
        1: write_cfg(CFG_LOG_SIZE, VAL_W'(12));
        2: write_cfg(CFG_LOG_SIZE, VAL_W'($urandom_range(7, 11)));
        default: write_cfg(CFG_LOG_SIZE, VAL_W'($urandom_range(1, 6)));
      endcase
    end
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 5))
        0: write_cfg(CFG_MODULUS, VAL_W'(2));
        1: write_cfg(CFG_MODULUS, {VAL_W{1'b1}});
        2: write_cfg(CFG_MODULUS, VAL_W'($urandom_range(2, 1000)));
        3: write_cfg(CFG_MODULUS, VAL_W'(3));
        default: write_cfg(CFG_MODULUS, (rand63() < 2) ? VAL_W'(2) : rand63());
      endcase
    end
    n = 1 << sb.eff_log();
    // full pass first on most small-size phases, a partial one on large sizes
    if (n <= 64) begin
      if ($urandom_range(0, 3) != 0) repeat (n) send_write(pick_coeff());
    end else begin
      repeat ($urandom_range(16, 48)) send_write(pick_coeff());
    end
    repeat ($urandom_range(10, 40)) begin
      if ($urandom_range(0, 2) == 0 || !sb.any_readable()) send_write(pick_coeff());
      else send_read(sb.pick_read_index());
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    sent_items = 0;
    stall_left = 0;
    idle_en = 1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_WRITE;
    req_ch.coeff_value = '0;
    req_ch.read_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GALOIS_INDEX;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: identity map on the full size
    send_write('0);
    send_write(COEFF_MAX);
    send_write(VAL_W'(5));
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(2));
    req_stop();
    wait_idle();

    // largest exponent, n = 4
    write_cfg(CFG_GALOIS_INDEX, VAL_W'(8191));
    write_cfg(CFG_LOG_SIZE, VAL_W'(2));
    write_cfg(CFG_MODULUS, {VAL_W{1'b1}});
    send_write('0);
    send_write(COEFF_MAX);
    send_write(VAL_W'(1));
    send_write(rand63());
    send_read({IDX_W{1'b1}});
    send_read(IDX_W'(0));
    send_read(IDX_W'(1));
    send_read(IDX_W'(2));
    req_stop();
    wait_idle();

    // smallest modulus, even exponent, coefficients at or above the modulus
    write_cfg(CFG_MODULUS, VAL_W'(2));
    write_cfg(CFG_GALOIS_INDEX, VAL_W'(2));
    write_cfg(CFG_LOG_SIZE, VAL_W'(1));
    send_write(VAL_W'(7));
    send_write(COEFF_MAX);
    send_read(IDX_W'(0));
    send_read({IDX_W{1'b1}});

    while (sent_items < 720) begin
      if (sent_items > 600) idle_en = 0;
      random_phase();
    end

    req_stop();
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
